[sv/b64d_pkg.sv]
`default_nettype none

package b64d_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_PAD   = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [6:0] SX_NONE  = 7'd64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } req_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    status_t    status;
  } res_t;

  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  count;
    logic        last;
    status_t     status;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = {1'b0, SX_NONE};
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end
    return d[6:0];
  endfunction

endpackage

`default_nettype wire

[sv/b64d_front.sv]
`default_nettype none

module b64d_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire b64d_pkg::req_t req,
  output logic               push,
  output b64d_pkg::grp_t     entry
);
  import b64d_pkg::*;

  logic [17:0] sbuf, sbuf_next;
  logic [1:0]  pos, pos_next;
  logic        twp, twp_next;
  logic        pgd, pgd_next;
  status_t     err, err_next;

  logic        pad;
  logic [6:0]  sx;
  logic [5:0]  s;
  logic [1:0]  cnt;
  logic [23:0] v;

  always_comb begin
    pad       = (req.char_in == CH_PAD);
    sx        = sextet_of(req.char_in);
    s         = pad ? 6'd0 : sx[5:0];
    v         = {sbuf, s};
    sbuf_next = sbuf;
    pos_next  = pos;
    twp_next  = twp;
    pgd_next  = pgd;
    err_next  = err;
    cnt       = 2'd0;
    if (err == ST_OK && !is_blank(req.char_in)) begin
      priority if (pgd) begin
        err_next = ST_BAD_PAD;
      end else if (!pad && sx[6]) begin
        err_next = ST_BAD_CHAR;
      end else if (pad && pos < 2'd2) begin
        err_next = ST_BAD_PAD;
      end else if (pos == 2'd3 && !pad && twp) begin
        err_next = ST_BAD_PAD;
      end else if (pos < 2'd3) begin
        if (pos == 2'd2 && pad) begin
          twp_next = 1'b1;
        end
        sbuf_next = {sbuf[11:0], s};
        pos_next  = pos + 2'd1;
      end else begin
        cnt       = twp ? 2'd1 : (pad ? 2'd2 : 2'd3);
        pgd_next  = pad || twp;
        sbuf_next = '0;
        pos_next  = 2'd0;
        twp_next  = 1'b0;
      end
    end
    if (req.end_of_text && err_next == ST_OK && pos_next != 2'd0) begin
      err_next = ST_BAD_LEN;
    end
    entry.bytes  = v;
    entry.count  = cnt;
    entry.last   = req.end_of_text;
    entry.status = err_next;
    push         = fire && (cnt != 2'd0 || req.end_of_text);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sbuf <= '0;
      pos  <= '0;
      twp  <= 1'b0;
      pgd  <= 1'b0;
      err  <= ST_OK;
    end else if (fire) begin
      if (req.end_of_text) begin
        sbuf <= '0;
        pos  <= '0;
        twp  <= 1'b0;
        pgd  <= 1'b0;
        err  <= ST_OK;
      end else begin
        sbuf <= sbuf_next;
        pos  <= pos_next;
        twp  <= twp_next;
        pgd  <= pgd_next;
        err  <= err_next;
      end
    end
  end

endmodule

`default_nettype wire

[sv/b64d_queue.sv]
`default_nettype none

module b64d_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire b64d_pkg::grp_t push_data,
  input  wire logic           pop,
  output b64d_pkg::grp_t      head,
  output b64d_pkg::q_stat_t   stat
);
  import b64d_pkg::*;

  grp_t           mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  assign head       = mem[rptr];
  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/b64d_back.sv]
`default_nettype none

module b64d_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b64d_pkg::grp_t    head,
  input  wire b64d_pkg::q_stat_t stat,
  output logic                   pop,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output b64d_pkg::res_t         res
);
  import b64d_pkg::*;

  logic [1:0] idx;
  logic [1:0] final_idx;
  logic       at_final;
  logic       fire;
  logic [7:0] sel;

  always_comb begin
    final_idx = (head.count == 2'd0) ? 2'd0 : head.count - 2'd1;
    at_final  = (idx == final_idx);
    res_valid = !stat.empty;
    fire      = res_valid && res_ready;
    pop       = fire && at_final;
    unique case (idx)
      2'd0:    sel = head.bytes[23:16];
      2'd1:    sel = head.bytes[15:8];
      default: sel = head.bytes[7:0];
    endcase
    res.byte_valid = (head.count != 2'd0);
    res.data_byte  = res.byte_valid ? sel : 8'd0;
    res.last       = head.last && at_final;
    res.status     = res.last ? head.status : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop) begin
      idx <= '0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

[sv/base64_decoder_checked.sv]
// channel | signals                     | direction | payload
// request | req_valid, req_ready, req   | in        | char_in, end_of_text
// result  | res_valid, res_ready, res   | out       | data_byte, byte_valid, last, status
//
// One request is taken per cycle while the group queue has room; the front
// classifies it and updates the group state in that cycle.
// A completed group or end of text puts one entry in the four-entry queue;
// the back drains it one result per cycle if res_ready is high (one to three per entry).
// Reset (rst, synchronous) empties the queue and clears the group state.
// A stalled result side stalls requests only once the queue is full.
`default_nettype none

module base64_decoder_checked (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire b64d_pkg::req_t req,
  output logic                res_valid,
  input  wire logic           res_ready,
  output b64d_pkg::res_t      res
);
  import b64d_pkg::*;

  grp_t    entry, head;
  q_stat_t stat;
  logic    push, pop, fire;

  assign req_ready = !stat.full;
  assign fire      = req_valid && req_ready;

  b64d_front u_front (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .req   (req),
    .push  (push),
    .entry (entry)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

[sv/b64d_checker.sv]
`default_nettype none

module b64d_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire b64d_pkg::req_t req,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire b64d_pkg::res_t res
);
  import b64d_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.last)
    else $error("error status on a result that is not last");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.byte_valid |-> res.last && res.data_byte == 8'd0)
    else $error("empty result that is not a clean closing result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered right after reset");

endmodule

bind base64_decoder_checked b64d_checker u_chk (.*);

`default_nettype wire
